// ----- hdl/tdbp_pkg.sv -----
// Package: widths, codes, payload types and helpers of the timestamp delta bit packer.
`timescale 1ns / 1ps
`default_nettype none
package tdbp_pkg;

  localparam int STAMP_W         = 64;
  localparam int BYTE_W          = 8;
  localparam int CNT_W           = 3;
  localparam int LEN_W           = 7;
  localparam int NB_W            = 4;
  localparam int ACC_W           = 72;
  localparam int HARD_LEN_CAP    = 56;
  localparam int DELTA_WIDTH_DEF = 31;
  localparam int RAW_BYTES       = 8;

  localparam logic KIND_STAMP = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic [STAMP_W-1:0] word;
    logic [NB_W-1:0]    nbytes;
    logic               error;
  } tdbp_word_t;

  function automatic logic [LEN_W-1:0] bit_length(input logic [STAMP_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < STAMP_W; i++) begin
      if (v[i]) n = LEN_W'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [STAMP_W-1:0] byte_swap(input logic [STAMP_W-1:0] v);
    logic [STAMP_W-1:0] r;
    r = '0;
    for (int i = 0; i < RAW_BYTES; i++) begin
      r[STAMP_W-1-BYTE_W*i -: BYTE_W] = v[BYTE_W*i +: BYTE_W];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/tdbp_if.sv -----
// Interfaces: input item channel and result byte channel.
`timescale 1ns / 1ps
`default_nettype none
interface tdbp_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] stamp_value;

  modport source (output valid, output kind, output stamp_value, input ready);
  modport sink   (input valid, input kind, input stamp_value, output ready);
endinterface

interface tdbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, output out_byte, output last, output error, input ready);
  modport sink   (input valid, input out_byte, input last, input error, output ready);
endinterface
`default_nettype wire

// ----- hdl/tdbp_encoder.sv -----
// Encoder: input register, coder state and single-pass bit packing into a byte word.
`timescale 1ns / 1ps
`default_nettype none
module tdbp_encoder #(
  parameter int DeltaWidth = tdbp_pkg::DELTA_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        kind_i,
  input  wire logic [tdbp_pkg::STAMP_W-1:0] stamp_value_i,
  input  wire logic                        can_load_i,
  output logic                             push_o,
  output tdbp_pkg::tdbp_word_t             word_o
);
  import tdbp_pkg::*;

  localparam int LenLimit = (DeltaWidth < HARD_LEN_CAP) ? DeltaWidth : HARD_LEN_CAP;

  logic               full_q;
  logic               kind_q;
  logic [STAMP_W-1:0] value_q;
  logic [STAMP_W-1:0] prev_q, prev_d;
  logic               seen_q, seen_d;
  logic [BYTE_W-1:0]  pend_q, pend_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic               advance;
  logic [STAMP_W-1:0] delta;
  logic [LEN_W-1:0]   len;
  logic               bad;
  logic [BYTE_W-1:0]  hdr;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   aligned;
  logic [LEN_W-1:0]   total;
  logic [BYTE_W-1:0]  rem_mask;
  tdbp_word_t         word;
  logic               emit;

  assign advance    = full_q && can_load_i;
  assign in_ready_o = !full_q || can_load_i;

  assign delta    = value_q - prev_q;
  assign len      = bit_length(delta);
  assign bad      = (value_q < prev_q) || (len > LEN_W'(LenLimit));
  assign hdr      = (len == '0) ? '0 : {1'b1, len};
  assign acc      = (ACC_W'({pend_q, hdr}) << len) | ACC_W'(delta);
  assign total    = LEN_W'(cnt_q) + LEN_W'(BYTE_W) + len;
  assign aligned  = acc << (LEN_W'(ACC_W) - total);
  assign rem_mask = BYTE_W'((9'd1 << total[CNT_W-1:0]) - 9'd1);

  always_comb begin
    word   = '0;
    emit   = 1'b0;
    prev_d = prev_q;
    seen_d = seen_q;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (kind_q == KIND_FLUSH) begin
      if (cnt_q != '0) begin
        emit        = 1'b1;
        word.nbytes = NB_W'(1);
        word.word   = {BYTE_W'(pend_q << (NB_W'(BYTE_W) - NB_W'(cnt_q))),
                       (STAMP_W-BYTE_W)'(0)};
        pend_d      = '0;
        cnt_d       = '0;
      end
    end else if (!seen_q) begin
      emit        = 1'b1;
      word.nbytes = NB_W'(RAW_BYTES);
      word.word   = byte_swap(value_q);
      prev_d      = value_q;
      seen_d      = 1'b1;
    end else if (bad) begin
      emit        = 1'b1;
      word.nbytes = NB_W'(1);
      word.error  = 1'b1;
    end else begin
      word.nbytes = total[LEN_W-1:CNT_W];
      emit        = (word.nbytes != '0);
      word.word   = aligned[ACC_W-1 -: STAMP_W];
      pend_d      = acc[BYTE_W-1:0] & rem_mask;
      cnt_d       = total[CNT_W-1:0];
      prev_d      = value_q;
    end
  end

  assign push_o = advance && emit;
  assign word_o = word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      prev_q <= '0;
      seen_q <= 1'b0;
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (advance) begin
        prev_q <= prev_d;
        seen_q <= seen_d;
        pend_q <= pend_d;
        cnt_q  <= cnt_d;
      end
      if (in_ready_o) full_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q  <= kind_i;
      value_q <= stamp_value_i;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tdbp_serializer.sv -----
// Serializer: result word register that hands out one byte per transaction.
`timescale 1ns / 1ps
`default_nettype none
module tdbp_serializer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire tdbp_pkg::tdbp_word_t         word_i,
  output logic                              can_load_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [tdbp_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                              last_o,
  output logic                              error_o
);
  import tdbp_pkg::*;

  logic [STAMP_W-1:0] word_q;
  logic [NB_W-1:0]    cnt_q;
  logic               err_q;
  logic               pop;

  assign out_valid_o = (cnt_q != '0);
  assign last_o      = (cnt_q == NB_W'(1));
  assign out_byte_o  = word_q[STAMP_W-1 -: BYTE_W];
  assign error_o     = err_q;
  assign pop         = out_valid_o && out_ready_i;
  assign can_load_o  = !out_valid_o || (last_o && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (push_i) begin
      cnt_q <= word_i.nbytes;
    end else if (pop) begin
      cnt_q <= cnt_q - NB_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      word_q <= word_i.word;
      err_q  <= word_i.error;
    end else if (pop) begin
      word_q <= word_q << BYTE_W;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/timestamp_delta_bit_packer.sv -----
// Path: an accepted item passes the input register, then the serializer's word register.
// Throughput: one item per cycle into the input register while the serializer can load;
// an item of n bytes holds the serializer until its last byte goes (one to five bytes by
// default for coded values, eight for a raw first value, one for an error); an empty
// flush yields no byte. Reset: rst_ni clears the coder state, the input full flag and the
// serializer byte count at once. Top level: timestamp delta bit packer.
`timescale 1ns / 1ps
`default_nettype none
module timestamp_delta_bit_packer #(
  parameter int DeltaWidth = tdbp_pkg::DELTA_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tdbp_in_if.sink    item_i,
  tdbp_out_if.source result_o
);
  import tdbp_pkg::*;

  logic       can_load;
  logic       push;
  tdbp_word_t word;

  tdbp_encoder #(
    .DeltaWidth(DeltaWidth)
  ) u_encoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (item_i.valid),
    .in_ready_o   (item_i.ready),
    .kind_i       (item_i.kind),
    .stamp_value_i(item_i.stamp_value),
    .can_load_i   (can_load),
    .push_o       (push),
    .word_o       (word)
  );

  tdbp_serializer u_serializer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .word_i     (word),
    .can_load_o (can_load),
    .out_valid_o(result_o.valid),
    .out_ready_i(result_o.ready),
    .out_byte_o (result_o.out_byte),
    .last_o     (result_o.last),
    .error_o    (result_o.error)
  );

endmodule
`default_nettype wire

// ----- hdl/tdbp_checker.sv -----
// Checker: port-level assertions of the timestamp delta bit packer and its bind.
`timescale 1ns / 1ps
`default_nettype none
module tdbp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i,
  input wire logic       out_error_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(out_last_i) && $stable(out_error_i))
    else $error("stalled result changed");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_error_i |-> out_last_i && (out_byte_i == 8'h00))
    else $error("error result is not a single zero byte");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("byte burst broken before last");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output idle");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind timestamp_delta_bit_packer tdbp_checker u_tdbp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (item_i.ready),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .out_byte_i (result_o.out_byte),
  .out_last_i (result_o.last),
  .out_error_i(result_o.error)
);
`default_nettype wire
